/* rtl/core/tlbpt_pkg.sv */
// Package with the sizes, widths and outcome codes of the TLB and page-table translator.
package tlbpt_pkg;

    // Sizes of the translation structures.
    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;

    // Derived index and value widths.
    localparam int TLB_IDX_W  = $clog2(TLB_ENTRIES);
    localparam int PAGE_IDX_W = $clog2(PAGE_COUNT);
    localparam int FRAME_W    = $clog2(FRAME_COUNT);

    // Fixed field widths of the address and the result.
    localparam int ADDR_W    = 16;
    localparam int PAGE_W    = 8;
    localparam int OFFSET_W  = 8;
    localparam int FRAME_OUT_W = 8;
    localparam int OUTCOME_W = 2;

    // Outcome codes of one translation.
    localparam logic [OUTCOME_W-1:0] OUTCOME_TLB_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_TABLE_HIT = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FAULT     = 2'd2;

endpackage

/* rtl/core/tlb_page_table_translate_core.sv */
// Top level of the address translator: register TLB with FIFO fill and a RAM page table.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_logical_address[15:0]
//  m_        out        m_valid / m_ready   m_frame_number, m_page_offset,
//                                           m_page_number, m_outcome
//
// A transaction is accepted in ST_IDLE, which issues the page-table RAM read;
// in ST_LOOKUP the block compares the TLB, uses the RAM data and writes back
// on a fault. The registered read of the page-table RAM sets this split.
// Reset (aresetn low, synchronous) clears the TLB valid bits, the present
// bits, the fill pointer and the free-frame counter; no clearing pass is run.
// A result waiting in the output register stalls the lookup cycle until taken.
module tlb_page_table_translate_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [tlbpt_pkg::ADDR_W-1:0]       s_logical_address,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tlbpt_pkg::FRAME_OUT_W-1:0]  m_frame_number,
    output logic [tlbpt_pkg::OFFSET_W-1:0]     m_page_offset,
    output logic [tlbpt_pkg::PAGE_W-1:0]       m_page_number,
    output logic [tlbpt_pkg::OUTCOME_W-1:0]    m_outcome
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    localparam int TLB_N   = tlbpt_pkg::TLB_ENTRIES;
    localparam int TIDX_W  = tlbpt_pkg::TLB_IDX_W;
    localparam int PIDX_W  = tlbpt_pkg::PAGE_IDX_W;
    localparam int FRM_W   = tlbpt_pkg::FRAME_W;
    localparam int PG_W    = tlbpt_pkg::PAGE_W;
    localparam int OFS_W   = tlbpt_pkg::OFFSET_W;
    localparam int FOUT_W  = tlbpt_pkg::FRAME_OUT_W;
    localparam int OC_W    = tlbpt_pkg::OUTCOME_W;
    localparam logic [TIDX_W-1:0] TLB_LAST   = TIDX_W'(tlbpt_pkg::TLB_ENTRIES - 1);
    localparam logic [FRM_W-1:0]  FRAME_LAST = FRM_W'(tlbpt_pkg::FRAME_COUNT - 1);

    state_t state_reg, state_next;

    // Captured transaction.
    logic [PG_W-1:0]  page_reg;
    logic [OFS_W-1:0] offset_reg;

    // TLB held in registers.
    logic [PG_W-1:0]   tlb_tag_reg   [TLB_N];
    logic [FRM_W-1:0]  tlb_frame_reg [TLB_N];
    logic [TLB_N-1:0]  tlb_valid_reg;
    logic [TIDX_W-1:0] fill_ptr_reg;
    logic [FRM_W-1:0]  free_frame_reg;

    // Present bits of the page table.
    logic [tlbpt_pkg::PAGE_COUNT-1:0] present_reg;

    // Output register.
    logic              m_valid_reg;
    logic [FOUT_W-1:0] m_frame_reg;
    logic [OFS_W-1:0]  m_offset_reg;
    logic [PG_W-1:0]   m_page_reg;
    logic [OC_W-1:0]   m_outcome_reg;

    logic              in_xact;
    logic              finish;
    logic [PG_W-1:0]   in_page;
    logic [PIDX_W-1:0] in_slot;
    logic [PIDX_W-1:0] cur_slot;
    logic [FRM_W-1:0]  table_rd_frame;
    logic              tlb_hit;
    logic [TIDX_W-1:0] hit_idx;
    logic              page_present;
    logic              fault_wr;
    logic [FRM_W-1:0]  result_frame;
    logic [OC_W-1:0]   result_outcome;

    assign in_xact = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign finish  = (state_reg == ST_LOOKUP) && (!m_valid_reg || m_ready);

    // Page-table slot is the page number modulo the table size.
    assign in_page  = s_logical_address[tlbpt_pkg::ADDR_W-1:OFS_W];
    assign in_slot  = PIDX_W'({{PIDX_W{1'b0}}, in_page});
    assign cur_slot = PIDX_W'({{PIDX_W{1'b0}}, page_reg});

    // Page-table frame store; read on accept, written back on a fault.
    tlbpt_ram #(
        .WIDTH (FRM_W),
        .DEPTH (tlbpt_pkg::PAGE_COUNT)
    ) u_table_frame (
        .aclk    (aclk),
        .wr_en   (fault_wr),
        .wr_addr (cur_slot),
        .wr_data (free_frame_reg),
        .rd_en   (in_xact),
        .rd_addr (in_slot),
        .rd_data (table_rd_frame)
    );

    // Parallel TLB compare; the lowest-numbered match wins.
    always_comb begin
        tlb_hit = 1'b0;
        hit_idx = '0;
        for (int i = TLB_N - 1; i >= 0; i--) begin
            if (tlb_valid_reg[i] && (tlb_tag_reg[i] == page_reg)) begin
                tlb_hit = 1'b1;
                hit_idx = TIDX_W'(i);
            end
        end
    end

    // Resolve the frame and the outcome of the current transaction.
    always_comb begin
        page_present = present_reg[cur_slot];
        if (tlb_hit) begin
            result_frame   = tlb_frame_reg[hit_idx];
            result_outcome = tlbpt_pkg::OUTCOME_TLB_HIT;
        end else if (page_present) begin
            result_frame   = table_rd_frame;
            result_outcome = tlbpt_pkg::OUTCOME_TABLE_HIT;
        end else begin
            result_frame   = free_frame_reg;
            result_outcome = tlbpt_pkg::OUTCOME_FAULT;
        end
    end

    assign fault_wr = finish && !tlb_hit && !page_present;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xact) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tlb_valid_reg  <= '0;
            fill_ptr_reg   <= '0;
            free_frame_reg <= '0;
            present_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (finish && !tlb_hit) begin
                tlb_valid_reg[fill_ptr_reg] <= 1'b1;
                fill_ptr_reg <= (fill_ptr_reg == TLB_LAST) ? '0 : fill_ptr_reg + 1'b1;
            end
            if (fault_wr) begin
                present_reg[cur_slot] <= 1'b1;
                free_frame_reg <= (free_frame_reg == FRAME_LAST) ? '0
                                                                 : free_frame_reg + 1'b1;
            end
        end
    end

    // Payload: captured address, TLB contents and the result.
    always_ff @(posedge aclk) begin
        if (in_xact) begin
            page_reg   <= in_page;
            offset_reg <= s_logical_address[OFS_W-1:0];
        end
        if (finish && !tlb_hit) begin
            tlb_tag_reg[fill_ptr_reg]   <= page_reg;
            tlb_frame_reg[fill_ptr_reg] <= result_frame;
        end
        if (finish) begin
            m_frame_reg   <= FOUT_W'({{FOUT_W{1'b0}}, result_frame});
            m_offset_reg  <= offset_reg;
            m_page_reg    <= page_reg;
            m_outcome_reg <= result_outcome;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_number = m_frame_reg;
    assign m_page_offset  = m_offset_reg;
    assign m_page_number  = m_page_reg;
    assign m_outcome      = m_outcome_reg;

endmodule

/* rtl/core/tlbpt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* test/tlb_page_table_translate_checker.sv */
// Checker that predicts each address translation and compares it with the block's result.
`timescale 1ns / 100ps

module tlb_page_table_translate_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [tlbpt_pkg::ADDR_W-1:0]      s_logical_address,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [tlbpt_pkg::FRAME_OUT_W-1:0] m_frame_number,
    input  logic [tlbpt_pkg::OFFSET_W-1:0]    m_page_offset,
    input  logic [tlbpt_pkg::PAGE_W-1:0]      m_page_number,
    input  logic [tlbpt_pkg::OUTCOME_W-1:0]   m_outcome,
    output int                                mismatch_count,
    output int                                pending_count
);

    localparam int ADDR_W      = tlbpt_pkg::ADDR_W;
    localparam int PAGE_W      = tlbpt_pkg::PAGE_W;
    localparam int OFFSET_W    = tlbpt_pkg::OFFSET_W;
    localparam int FRAME_W     = tlbpt_pkg::FRAME_W;
    localparam int FRAME_OUT_W = tlbpt_pkg::FRAME_OUT_W;
    localparam int OUTCOME_W   = tlbpt_pkg::OUTCOME_W;
    localparam int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES;
    localparam int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT;
    localparam int FRAME_COUNT = tlbpt_pkg::FRAME_COUNT;

    typedef struct packed {
        logic [FRAME_OUT_W-1:0] frame;
        logic [OFFSET_W-1:0]    offset;
        logic [PAGE_W-1:0]      page;
        logic [OUTCOME_W-1:0]   outcome;
    } translation_t;

    // Shadow copy of the TLB, the page table and the two counters.
    logic [PAGE_W-1:0]  tlb_page      [TLB_ENTRIES];
    logic [FRAME_W-1:0] tlb_frame     [TLB_ENTRIES];
    logic               tlb_valid     [TLB_ENTRIES];
    logic [FRAME_W-1:0] table_frame   [PAGE_COUNT];
    logic               table_present [PAGE_COUNT];
    int                 fill_ptr;
    int                 next_frame;

    translation_t expected_translations[$];
    translation_t got_translation;
    translation_t want_translation;

    // Translates one address and updates the shadow state the way the block must.
    function automatic translation_t translate_address(input logic [ADDR_W-1:0] addr);
        translation_t       result;
        int                 hit_idx;
        int                 slot;
        logic [FRAME_W-1:0] frame;
        hit_idx       = -1;
        result.page   = addr[ADDR_W-1 -: PAGE_W];
        result.offset = addr[OFFSET_W-1:0];
        slot          = int'(result.page) % PAGE_COUNT;
        // The lowest-numbered matching entry wins.
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (hit_idx < 0 && tlb_valid[i] && tlb_page[i] == result.page) begin
                hit_idx = i;
            end
        end
        if (hit_idx >= 0) begin
            frame          = tlb_frame[hit_idx];
            result.outcome = tlbpt_pkg::OUTCOME_TLB_HIT;
        end else begin
            if (table_present[slot]) begin
                frame          = table_frame[slot];
                result.outcome = tlbpt_pkg::OUTCOME_TABLE_HIT;
            end else begin
                // Page fault: take the next free frame; the counter wraps.
                frame               = FRAME_W'(next_frame);
                table_frame[slot]   = frame;
                table_present[slot] = 1'b1;
                next_frame          = (next_frame + 1) % FRAME_COUNT;
                result.outcome      = tlbpt_pkg::OUTCOME_FAULT;
            end
            // Every miss installs the page at the FIFO fill pointer.
            tlb_page[fill_ptr]  = result.page;
            tlb_frame[fill_ptr] = frame;
            tlb_valid[fill_ptr] = 1'b1;
            fill_ptr            = (fill_ptr + 1) % TLB_ENTRIES;
        end
        result.frame = FRAME_OUT_W'(frame);
        return result;
    endfunction

    // Compare each result transaction first, then predict any new address transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                tlb_valid[i] = 1'b0;
            end
            for (int i = 0; i < PAGE_COUNT; i++) begin
                table_present[i] = 1'b0;
            end
            fill_ptr   = 0;
            next_frame = 0;
            expected_translations.delete();
            mismatch_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got_translation = '{m_frame_number, m_page_offset, m_page_number, m_outcome};
                if (expected_translations.size() == 0) begin
                    $display("%0t: result with no transaction pending: %s %0d %0d %0d %0d",
                             $time, "frame/offset/page/outcome",
                             got_translation.frame, got_translation.offset,
                             got_translation.page, got_translation.outcome);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want_translation = expected_translations.pop_front();
                    if (got_translation !== want_translation) begin
                        $display("%0t: mismatch: expected frame %0d offset %0d page %0d %s %0d,",
                                 $time, want_translation.frame, want_translation.offset,
                                 want_translation.page, "outcome", want_translation.outcome);
                        $display("%0t:           got frame %0d offset %0d page %0d %s %0d",
                                 $time, got_translation.frame, got_translation.offset,
                                 got_translation.page, "outcome", got_translation.outcome);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_translations.push_back(translate_address(s_logical_address));
            end
        end
        pending_count <= expected_translations.size();
    end

endmodule

/* test/tlb_page_table_translate_core_tb.sv */
// Testbench top for the TLB and page-table translator: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tlb_page_table_translate_core_tb;

    localparam int ADDR_W      = tlbpt_pkg::ADDR_W;
    localparam int PAGE_W      = tlbpt_pkg::PAGE_W;
    localparam int OFFSET_W    = tlbpt_pkg::OFFSET_W;
    localparam int FRAME_OUT_W = tlbpt_pkg::FRAME_OUT_W;
    localparam int OUTCOME_W   = tlbpt_pkg::OUTCOME_W;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 110;

    logic                   aclk;
    logic                   aresetn           = 1'b0;
    logic                   s_valid           = 1'b0;
    logic                   s_ready;
    logic [ADDR_W-1:0]      s_logical_address = '0;
    logic                   m_valid;
    logic                   m_ready           = 1'b0;
    logic [FRAME_OUT_W-1:0] m_frame_number;
    logic [OFFSET_W-1:0]    m_page_offset;
    logic [PAGE_W-1:0]      m_page_number;
    logic [OUTCOME_W-1:0]   m_outcome;

    int mismatch_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hot_base       = 0;
    int idle_cycles    = 0;
    bit hold_request   = 1'b0;

    tlb_page_table_translate_core u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_logical_address (s_logical_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_number    (m_frame_number),
        .m_page_offset     (m_page_offset),
        .m_page_number     (m_page_number),
        .m_outcome         (m_outcome)
    );

    tlb_page_table_translate_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_logical_address (s_logical_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_number    (m_frame_number),
        .m_page_offset     (m_page_offset),
        .m_page_number     (m_page_number),
        .m_outcome         (m_outcome),
        .mismatch_count    (mismatch_count),
        .pending_count     (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: random stalls, or one long hold-off when requested.
    initial begin
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge aclk);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one address after a random gap and returns once it is accepted.
    task automatic send_address(input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_logical_address <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering and waits until every predicted translation has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // Mostly a sliding window of hot pages and repeats, so that TLB hits, table hits
    // and faults all occur; the window sweeps every page over the run.
    task automatic run_random_phase(input int send_idle, input int recv_stall);
        int                choice;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] last_page;
        last_page      = '0;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            choice = $urandom_range(99);
            if (choice < 55) begin
                page = PAGE_W'((hot_base + $urandom_range(19)) % 256);
            end else if (choice < 80) begin
                page = last_page;
            end else begin
                page = PAGE_W'($urandom_range(255));
            end
            if ($urandom_range(99) < 60) begin
                hot_base++;
            end
            send_address({page, OFFSET_W'($urandom)});
            last_page = page;
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: address extremes, hits on both ends of a page, then enough
        // new pages to wrap the TLB so an evicted page comes back from the table.
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFFFF);
        send_address(16'hFF00);
        send_address(16'h5AA5);
        send_address(16'hA55A);
        for (int p = 1; p <= 12; p++) begin
            send_address({PAGE_W'(p), OFFSET_W'(p * 17)});
        end
        send_address(16'h0D3C);
        send_address(16'h0042);
        send_address(16'h0180);
        send_address(16'hFF7E);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering back to back.
        hold_request = 1'b1;
        run_random_phase(0, 0);
        wait_drained();
        run_random_phase(68, 0);
        wait_drained();
        run_random_phase(0, 68);
        wait_drained();
        run_random_phase(7, 7);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tlbpt_pkg.sv
rtl/core/tlbpt_ram.sv
rtl/core/tlb_page_table_translate_core.sv
test/tlb_page_table_translate_checker.sv
test/tlb_page_table_translate_core_tb.sv
